// File: hdl/fas_pkg.sv
// shared types and constants of the frame animation sequencer
`default_nettype none

package fas_pkg;

  localparam int TIME_BITS     = 32;
  localparam int MAX_FRAMES    = 256;
  localparam int FRAME_W       = 8;
  localparam int FCOUNT_W      = 9;
  localparam int SPEED_W       = 16;
  localparam int SPEED_FRAC    = 8;
  localparam int DELAY_W       = 16;
  localparam int WAIT_W        = 16;
  localparam int SKIP_W        = 40;
  localparam int PROD_W        = SKIP_W + DELAY_W;
  localparam int DIV_W         = 64;
  localparam int DIV_REM_W     = 16;
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_CNT_W     = 5;
  localparam int MOD_W         = 48;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int IN_DATA_W     = 64;
  localparam int IN_USER_W     = 2;
  localparam int OUT_DATA_W    = 16;

  localparam logic [DIV_CNT_W-1:0] Q_STEPS   = DIV_CNT_W'(TIME_BITS / DIV_STEP_BITS);
  localparam logic [DIV_CNT_W-1:0] ADV_STEPS = DIV_CNT_W'(DIV_W / DIV_STEP_BITS);
  localparam logic [DIV_CNT_W-1:0] MOD_STEPS = DIV_CNT_W'(MOD_W / DIV_STEP_BITS);

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_SPEED         = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_COUNT   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LOOP_ENABLE   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PINGPONG      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PLAY_BACKWARD = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LOOP_WAIT     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_LOOP_WAIT_RND = 3'd6;

  typedef struct packed {
    logic [SPEED_W-1:0]  speed;
    logic [FCOUNT_W-1:0] fcount;
    logic                loop_en;
    logic                pp_en;
    logic                play_bwd;
    logic [WAIT_W-1:0]   loop_wait;
    logic [WAIT_W-1:0]   loop_wait_rnd;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_W-1:0]     dividend;
    logic [DIV_REM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_W-1:0]     quot;
    logic [DIV_REM_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: hdl/fas_cfg_regs.sv
// configuration registers with the sanitized values used by the sequencer
`default_nettype none

module fas_cfg_regs
  import fas_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  logic [SPEED_W-1:0]  speed_r;
  logic [FCOUNT_W-1:0] fcount_r;
  logic                loop_en_r;
  logic                pp_en_r;
  logic                play_bwd_r;
  logic [WAIT_W-1:0]   loop_wait_r;
  logic [WAIT_W-1:0]   loop_wait_rnd_r;
  logic                wr_en;

  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r         <= SPEED_W'(256);
      fcount_r        <= FCOUNT_W'(1);
      loop_en_r       <= 1'b1;
      pp_en_r         <= 1'b0;
      play_bwd_r      <= 1'b0;
      loop_wait_r     <= '0;
      loop_wait_rnd_r <= '0;
    end else if (wr_en) begin
      case (cfg_addr)
        REG_SPEED:         speed_r         <= cfg_data[SPEED_W-1:0];
        REG_FRAME_COUNT:   fcount_r        <= cfg_data[FCOUNT_W-1:0];
        REG_LOOP_ENABLE:   loop_en_r       <= cfg_data[0];
        REG_PINGPONG:      pp_en_r         <= cfg_data[0];
        REG_PLAY_BACKWARD: play_bwd_r      <= cfg_data[0];
        REG_LOOP_WAIT:     loop_wait_r     <= cfg_data[WAIT_W-1:0];
        REG_LOOP_WAIT_RND: loop_wait_rnd_r <= cfg_data[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero speed runs as the smallest step, frame count clamps to 1..MAX_FRAMES
  always_comb begin
    cfg.speed = (speed_r == '0) ? SPEED_W'(1) : speed_r;
    if (fcount_r == '0)
      cfg.fcount = FCOUNT_W'(1);
    else if (fcount_r > FCOUNT_W'(MAX_FRAMES))
      cfg.fcount = FCOUNT_W'(MAX_FRAMES);
    else
      cfg.fcount = fcount_r;
    cfg.loop_en       = loop_en_r;
    cfg.pp_en         = pp_en_r;
    cfg.play_bwd      = play_bwd_r;
    cfg.loop_wait     = loop_wait_r;
    cfg.loop_wait_rnd = loop_wait_rnd_r;
  end

endmodule

`default_nettype wire

// File: hdl/fas_div.sv
// shared restoring divider, four quotient bits per cycle, 16-bit divisor
`default_nettype none

module fas_div
  import fas_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  div_req_t  req,
  output div_rsp_t  rsp
);

  logic [DIV_W-1:0]     dvd_r, dvd_nxt;
  logic [DIV_REM_W-1:0] rem_r, rem_nxt;
  logic [DIV_REM_W-1:0] dvsr_r, dvsr_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_W-1:0]     step_dvd;
  logic [DIV_REM_W-1:0] step_rem;
  logic [DIV_REM_W:0]   trial;

  // dividend shifts out at the top, quotient bits enter at the bottom
  always_comb begin
    step_dvd = dvd_r;
    step_rem = rem_r;
    trial    = '0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      trial    = {step_rem, step_dvd[DIV_W-1]};
      step_dvd = {step_dvd[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvsr_r}) begin
        trial       = trial - {1'b0, dvsr_r};
        step_dvd[0] = 1'b1;
      end
      step_rem = trial[DIV_REM_W-1:0];
    end
  end

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      dvsr_nxt = req.divisor;
      cnt_nxt  = req.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = step_dvd;
      rem_nxt = step_rem;
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;
  assign rsp.rem  = rem_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

endmodule

`default_nettype wire

// File: hdl/frame_animation_sequencer_core.sv
// Time-driven animation frame stepper: each input is a tick, start or finish.
// Input stream: in_tuser carries the action (tick, start, finish); in_tdata
// carries time_now, frame_delay and random_draw. Every input gives exactly
// one result on the output stream: frame_index, done_res, going_backward and
// frame_changed. The user must write registers on the cfg channel only
// while idle; the block itself does not enforce this. A tick that steps the
// animation runs up to three divisions on one shared radix-16 divider (8, 16
// and 12 steps) with two multiplies in between; it stops after two when the
// animation finishes without looping. Start, finish, ignored codes and ticks
// that do not step go from idle straight to the output state. in_tready is
// high only in the idle state, so one item is in work at a time.
// The output register holds a result until it is taken; the next input is
// still accepted meanwhile, and its result waits in the sequencer until the
// output register is free, with in_tready low.
// Synchronous reset clears the frame, step time, direction and finished flag
// to zero and loads the register defaults (speed 256, one frame, looping).
`default_nettype none

module frame_animation_sequencer_core
  import fas_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // time_now[31:0], frame_delay[47:32], random_draw[63:48]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // frame_index[7:0], done_res[8], going_backward[9], frame_changed[10], zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIVQ   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_ADV_GO = 3'd3;
  localparam logic [2:0] S_ADV    = 3'd4;
  localparam logic [2:0] S_MOD_GO = 3'd5;
  localparam logic [2:0] S_MOD    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [2:0]            state_r, state_nxt;
  logic [FRAME_W-1:0]    cur_r, cur_nxt;
  logic [TIME_BITS-1:0]  last_r, last_nxt;
  logic                  bwd_r, bwd_nxt;
  logic                  fin_r, fin_nxt;
  logic                  chg_r, chg_nxt;
  logic                  end_r, end_nxt;
  logic [DELAY_W-1:0]    delay_r, delay_nxt;
  logic [WAIT_W-1:0]     draw_r, draw_nxt;
  logic [SKIP_W-1:0]     skip_r, skip_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [MOD_W-1:0]      modx_r, modx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                  in_acc;
  logic [1:0]            act;
  logic [TIME_BITS-1:0]  t_now;
  logic [DELAY_W-1:0]    dly_raw, dly;
  logic [TIME_BITS-1:0]  elapsed;
  logic [TIME_BITS+SPEED_W-1:0] speed_prod;
  logic [SKIP_W:0]       sum_fwd;
  logic                  reach_end;
  logic [FCOUNT_W-1:0]   mod_r9;
  logic [FCOUNT_W-1:0]   next_fr;
  logic                  wait_add;
  logic [WAIT_W-1:0]     draw_min;
  logic [TIME_BITS-1:0]  wait_term;

  fas_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fas_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign act       = in_tuser[1:0];
  assign t_now     = in_tdata[TIME_BITS-1:0];
  assign dly_raw   = in_tdata[TIME_BITS+DELAY_W-1:TIME_BITS];
  assign dly       = (dly_raw == '0) ? DELAY_W'(1) : dly_raw;
  assign elapsed   = t_now - last_r;

  assign speed_prod = div_rsp.quot[TIME_BITS-1:0] * cfg.speed;
  assign sum_fwd    = {1'b0, skip_r} + (SKIP_W+1)'(cur_r);
  assign reach_end  = bwd_r ? (skip_r > SKIP_W'(cur_r))
                            : (sum_fwd >= (SKIP_W+1)'(cfg.fcount));
  assign mod_r9     = div_rsp.rem[FCOUNT_W-1:0];

  // randomized loop wait: loop_wait - span/2 + min(draw, span)
  assign draw_min  = (draw_r < cfg.loop_wait_rnd) ? draw_r : cfg.loop_wait_rnd;
  assign wait_term = TIME_BITS'(cfg.loop_wait) + TIME_BITS'(draw_min)
                   - TIME_BITS'(cfg.loop_wait_rnd[WAIT_W-1:1]);

  // divider request per sequencer step
  always_comb begin
    div_req.start    = 1'b0;
    div_req.steps    = Q_STEPS;
    div_req.dividend = {elapsed, (DIV_W-TIME_BITS)'(0)};
    div_req.divisor  = dly;
    case (state_r)
      S_IDLE: begin
        div_req.start = in_acc && (act == ACT_TICK) && !fin_r
                        && (elapsed >= TIME_BITS'(dly));
      end
      S_ADV_GO: begin
        div_req.start    = 1'b1;
        div_req.steps    = ADV_STEPS;
        div_req.dividend = {prod_r, (DIV_W-PROD_W)'(0)};
        div_req.divisor  = cfg.speed;
      end
      S_MOD_GO: begin
        div_req.start    = 1'b1;
        div_req.steps    = MOD_STEPS;
        div_req.dividend = {modx_r, (DIV_W-MOD_W)'(0)};
        div_req.divisor  = DIV_REM_W'(cfg.fcount);
      end
      default: ;
    endcase
  end

  // frame wrap, reflection or backward wrap from the remainder
  always_comb begin
    next_fr  = mod_r9;
    wait_add = 1'b0;
    if (!bwd_r) begin
      if (cfg.pp_en && end_r) begin
        if ((FCOUNT_W+1)'(mod_r9) + (FCOUNT_W+1)'(2) > (FCOUNT_W+1)'(cfg.fcount)) begin
          next_fr  = '0;
          wait_add = 1'b1;
        end else begin
          next_fr = cfg.fcount - mod_r9 - FCOUNT_W'(2);
        end
      end
    end else if (end_r) begin
      if (cfg.pp_en)
        wait_add = 1'b1;
      else
        next_fr = (mod_r9 != '0) ? (cfg.fcount - mod_r9) : '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    last_nxt      = last_r;
    bwd_nxt       = bwd_r;
    fin_nxt       = fin_r;
    chg_nxt       = chg_r;
    end_nxt       = end_r;
    delay_nxt     = delay_r;
    draw_nxt      = draw_r;
    skip_nxt      = skip_r;
    prod_nxt      = prod_r;
    modx_nxt      = modx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready)
      out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          chg_nxt   = 1'b0;
          delay_nxt = dly;
          draw_nxt  = in_tdata[IN_DATA_W-1:TIME_BITS+DELAY_W];
          state_nxt = S_OUT;
          case (act)
            ACT_TICK: begin
              if (div_req.start)
                state_nxt = S_DIVQ;
            end
            ACT_START: begin
              fin_nxt  = 1'b0;
              last_nxt = t_now;
              bwd_nxt  = cfg.play_bwd;
            end
            ACT_FINISH: fin_nxt = 1'b1;
            default: ;
          endcase
        end
      end
      S_DIVQ: begin
        if (div_rsp.done) begin
          skip_nxt  = speed_prod[TIME_BITS+SPEED_W-1:SPEED_FRAC];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = skip_r * delay_r;
        state_nxt = S_ADV_GO;
      end
      S_ADV_GO: state_nxt = S_ADV;
      S_ADV: begin
        if (div_rsp.done) begin
          last_nxt = last_r + div_rsp.quot[TIME_BITS-1:0];
          end_nxt  = reach_end;
          if (reach_end && !cfg.loop_en && (!cfg.pp_en || bwd_r)) begin
            fin_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_MOD_GO;
            if (!bwd_r)
              modx_nxt = MOD_W'(sum_fwd);
            else if (!reach_end)
              modx_nxt = MOD_W'(cur_r - skip_r[FRAME_W-1:0]);
            else
              modx_nxt = MOD_W'(skip_r - SKIP_W'(cur_r));
          end
        end
      end
      S_MOD_GO: state_nxt = S_MOD;
      S_MOD: begin
        if (div_rsp.done) begin
          if (end_r && cfg.pp_en)
            bwd_nxt = !bwd_r;
          if (wait_add && (cfg.loop_wait != '0))
            last_nxt = last_r + wait_term;
          cur_nxt   = next_fr[FRAME_W-1:0];
          chg_nxt   = (next_fr[FRAME_W-1:0] != cur_r);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(OUT_DATA_W-FRAME_W-3)'(0), chg_r, bwd_r, fin_r, cur_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      last_r      <= '0;
      bwd_r       <= 1'b0;
      fin_r       <= 1'b0;
      chg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      last_r      <= last_nxt;
      bwd_r       <= bwd_nxt;
      fin_r       <= fin_nxt;
      chg_r       <= chg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r      <= end_nxt;
    delay_r    <= delay_nxt;
    draw_r     <= draw_nxt;
    skip_r     <= skip_nxt;
    prod_r     <= prod_nxt;
    modx_r     <= modx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIVQ || state_r == S_ADV || state_r == S_MOD))
    else $error("divider finished outside a wait state");

  a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD && div_rsp.done) |=> (chg_r == (cur_r != $past(cur_r))))
    else $error("frame_changed disagrees with the frame update");

  a_finished_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && act == ACT_TICK && fin_r) |=> ($stable(cur_r) && state_r == S_OUT))
    else $error("tick moved a finished animation");

endmodule

`default_nettype wire
